>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bit store block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define BRCQ_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is asserted.
`define BRCQ_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

>>> design/brcq_pkg.sv
// ----------------------------------------------------------------------------
// brcq_pkg
// Types, command codes and the byte mask helper for the bit store block.
// ----------------------------------------------------------------------------
`default_nettype none

package brcq_pkg;

	localparam int ADDR_W = 10;
	localparam int BIT_W  = 3;

	// Request commands as they arrive on the input channel.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	// Operation kinds held in the queue.
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_ZERO  = 2'd3;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] s;
		logic [BIT_W-1:0]  sbit;
		logic [ADDR_W-1:0] e;
		logic [BIT_W-1:0]  ebit;
		logic [7:0]        value;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic init_busy;
		logic res_pend;
	} back_stat_t;

	// Bits of one byte that lie inside the range; bit 7 comes first.
	function automatic logic [7:0] span_mask(input logic first, input logic last,
			input logic [BIT_W-1:0] sbit, input logic [BIT_W-1:0] ebit);
		logic [BIT_W-1:0] hi;
		logic [BIT_W-1:0] lo;
		logic [8:0]       upper;
		logic [8:0]       lower;
		hi    = first ? sbit : 3'd7;
		lo    = last ? ebit : 3'd0;
		upper = (9'd1 << (4'(hi) + 4'd1)) - 9'd1;
		lower = (9'd1 << lo) - 9'd1;
		if (hi < lo) begin
			return 8'd0;
		end
		return upper[7:0] & ~lower[7:0];
	endfunction

endpackage

`default_nettype wire

>>> design/brcq_front.sv
// ----------------------------------------------------------------------------
// brcq_front
// Accepts requests, drops those with no effect and trims ranges to the store.
// ----------------------------------------------------------------------------
`default_nettype none

module brcq_front #(
	parameter int BYTES = 1024
) (
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           cmd,
	input  wire logic [9:0]           start_byte,
	input  wire logic [2:0]           start_bit,
	input  wire logic [9:0]           end_byte,
	input  wire logic [2:0]           end_bit,
	input  wire logic [7:0]           load_value,
	input  wire brcq_pkg::q_stat_t    q_stat,
	input  wire brcq_pkg::back_stat_t b_stat,
	output logic                      push,
	output brcq_pkg::op_t             push_op
);
	import brcq_pkg::*;

	logic accept;
	logic start_in;
	logic end_in;
	logic empty_range;
	logic keep;

	always_comb begin
		in_stall    = q_stat.full | b_stat.init_busy;
		accept      = in_valid & ~in_stall;
		start_in    = 32'(start_byte) < 32'(BYTES);
		end_in      = 32'(end_byte) < 32'(BYTES);
		empty_range = !start_in || (start_byte > end_byte) ||
			((start_byte == end_byte) && (end_bit > start_bit));

		// A range running past the store ends with the whole of its last byte.
		push_op.s     = start_byte;
		push_op.sbit  = start_bit;
		push_op.e     = end_in ? end_byte : ADDR_W'(BYTES - 1);
		push_op.ebit  = end_in ? end_bit : 3'd0;
		push_op.value = load_value;

		unique case (cmd)
			CMD_LOAD: begin
				push_op.kind = OP_LOAD;
				keep         = start_in;
			end
			CMD_CLEAR: begin
				push_op.kind = OP_CLEAR;
				keep         = !empty_range;
			end
			CMD_QUERY: begin
				push_op.kind = empty_range ? OP_ZERO : OP_QUERY;
				keep         = 1'b1;
			end
			default: begin
				push_op.kind = OP_LOAD;
				keep         = 1'b0;
			end
		endcase

		push = accept & keep;
	end

endmodule

`default_nettype wire

>>> design/brcq_queue.sv
// ----------------------------------------------------------------------------
// brcq_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module brcq_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire brcq_pkg::op_t push_op,
	input  wire logic          pop,
	output brcq_pkg::op_t      head_op,
	output brcq_pkg::q_stat_t  q_stat
);
	import brcq_pkg::*;

	op_t            entry_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	always_comb begin
		head_op      = entry_q[rd_ptr_q];
		q_stat.full  = count_q == (QAW + 1)'(QDEPTH);
		q_stat.empty = count_q == '0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/brcq_back.sv
// ----------------------------------------------------------------------------
// brcq_back
// Executes queued operations on the byte store, one byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module brcq_back #(
	parameter int BYTES = 1024
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire brcq_pkg::op_t   head_op,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 any_set,
	output brcq_pkg::back_stat_t b_stat
);
	import brcq_pkg::*;

	localparam int AW = (BYTES > 1) ? $clog2(BYTES) : 1;

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;

	logic [7:0]        mem [BYTES];
	logic [7:0]        rd_data_s1;

	logic [1:0]        state_q;
	logic [AW-1:0]     init_q;
	op_t               cur_op_q;
	logic [ADDR_W-1:0] cur_q;
	logic              valid_s1;
	logic              first_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              found_q;
	logic              res_pend_q;
	logic              res_q;
	logic              out_valid_q;
	logic              any_set_q;

	logic              can_start;
	logic              walk_start;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [7:0]        wdata;
	logic [7:0]        mask;
	logic              hit;
	logic              res_set;
	logic              res_val;
	logic              res_take;

	always_comb begin
		can_start = q_valid && !valid_s1 && (state_q == ST_IDLE);
		unique case (head_op.kind)
			OP_LOAD:  pop = can_start;
			OP_CLEAR: pop = can_start;
			OP_QUERY: pop = can_start && !res_pend_q;
			OP_ZERO:  pop = can_start && !res_pend_q;
			default:  pop = 1'b0;
		endcase
		walk_start = pop && ((head_op.kind == OP_CLEAR) || (head_op.kind == OP_QUERY));

		mask = span_mask(first_s1, last_s1, cur_op_q.sbit, cur_op_q.ebit);
		hit  = |(rd_data_s1 & mask);

		we    = 1'b0;
		waddr = init_q;
		wdata = 8'd0;
		priority if (state_q == ST_INIT) begin
			we = 1'b1;
		end else if (pop && (head_op.kind == OP_LOAD)) begin
			we    = 1'b1;
			waddr = AW'(head_op.s);
			wdata = head_op.value;
		end else if (valid_s1 && (cur_op_q.kind == OP_CLEAR)) begin
			we    = 1'b1;
			waddr = AW'(addr_s1);
			wdata = rd_data_s1 & ~mask;
		end

		res_set = 1'b0;
		res_val = 1'b0;
		if (pop && (head_op.kind == OP_ZERO)) begin
			res_set = 1'b1;
		end else if (valid_s1 && last_s1 && (cur_op_q.kind == OP_QUERY)) begin
			res_set = 1'b1;
			res_val = found_q | hit;
		end
		res_take = res_pend_q && (!out_valid_q || !out_stall);

		out_valid        = out_valid_q;
		any_set          = any_set_q;
		b_stat.init_busy = state_q == ST_INIT;
		b_stat.res_pend  = res_pend_q;
	end

	// Store: one write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (state_q == ST_WALK) begin
			rd_data_s1 <= mem[AW'(cur_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (walk_start) begin
			cur_op_q <= head_op;
		end
		addr_s1  <= cur_q;
		first_s1 <= cur_q == cur_op_q.s;
		last_s1  <= cur_q == cur_op_q.e;
		if (res_set) begin
			res_q <= res_val;
		end
		if (!out_valid_q || !out_stall) begin
			any_set_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_q      <= '0;
			cur_q       <= '0;
			valid_s1    <= 1'b0;
			found_q     <= 1'b0;
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= state_q == ST_WALK;
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == AW'(BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (walk_start) begin
						state_q <= ST_WALK;
						cur_q   <= head_op.s;
						found_q <= 1'b0;
					end
				end
				ST_WALK: begin
					cur_q <= cur_q + 1'b1;
					if (cur_q == cur_op_q.e) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (valid_s1 && hit) begin
				found_q <= 1'b1;
			end

			// A new result only arrives when none is waiting, so set wins.
			if (res_set) begin
				res_pend_q <= 1'b1;
			end else if (res_take) begin
				res_pend_q <= 1'b0;
			end

			if (!out_valid_q || !out_stall) begin
				out_valid_q <= res_pend_q;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/bitmap_range_clear_any_query.sv
// ----------------------------------------------------------------------------
// bitmap_range_clear_any_query
// Bit store with byte load, bit range clear and any-bit-set range query.
// ----------------------------------------------------------------------------
// After reset the store is zeroed by a sweep, one byte a cycle, during which
// in_stall stays high. A load then writes its byte directly in the execution
// engine; a clear or query walks every byte it spans, because the single
// read port of the store is walked one byte per cycle. A four-entry queue
// decouples request intake from execution, and a query result waits in an
// output register so that further requests are taken while it is held by
// out_stall.
`default_nettype none

`include "assert_macros.svh"

module bitmap_range_clear_any_query #(
	parameter int BYTES = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] cmd,
	input  wire logic [9:0] start_byte,
	input  wire logic [2:0] start_bit,
	input  wire logic [9:0] end_byte,
	input  wire logic [2:0] end_bit,
	input  wire logic [7:0] load_value,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            any_set
);
	import brcq_pkg::*;

	logic       q_push;
	op_t        q_push_op;
	logic       q_pop;
	op_t        q_head_op;
	logic       q_valid;
	q_stat_t    q_stat;
	back_stat_t b_stat;

	assign q_valid = !q_stat.empty;

	brcq_front #(
		.BYTES (BYTES)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.start_byte (start_byte),
		.start_bit  (start_bit),
		.end_byte   (end_byte),
		.end_bit    (end_bit),
		.load_value (load_value),
		.q_stat     (q_stat),
		.b_stat     (b_stat),
		.push       (q_push),
		.push_op    (q_push_op)
	);

	brcq_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_push_op),
		.pop     (q_pop),
		.head_op (q_head_op),
		.q_stat  (q_stat)
	);

	brcq_back #(
		.BYTES (BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head_op   (q_head_op),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.any_set   (any_set),
		.b_stat    (b_stat)
	);

	// Nothing may reach the queue while the store is still being zeroed.
	`BRCQ_ASSERT_IMPLY(a_init_queue_empty, clk, arst_n, b_stat.init_busy, q_stat.empty)
	`BRCQ_ASSERT_IMPLY(a_init_no_pop, clk, arst_n, b_stat.init_busy, !q_pop)
	// After a result is taken, the output only refills from a waiting result.
	`BRCQ_ASSERT_NEXT(a_out_refill, clk, arst_n, out_valid && !out_stall, !out_valid || $past(b_stat.res_pend))

endmodule

`default_nettype wire
